// ===== hw/rtl/rmq_pkg.sv =====
// Shared constants and types for the rotation matrix to quaternion block.
// Used by the channel interfaces and every module of the block; no dependencies.
`default_nettype none

package rmq_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  localparam int LANES   = 4;
  localparam int LANE_W  = 0;
  localparam int LANE_X  = 1;
  localparam int LANE_Y  = 2;
  localparam int LANE_Z  = 3;

  localparam int SUM_W    = DATA_WIDTH + 3;
  localparam int RAD_BASE = SUM_W - 1 + FRAC_BITS - 2;
  localparam int RAD_W    = 2 * ((RAD_BASE + 1) / 2);
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 3;
  localparam int MAG_W    = FRAC_BITS + 1;
  localparam int ONE      = 1 << FRAC_BITS;

  localparam int PIPE_STAGES = ROOT_W + 2;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic        [DATA_WIDTH-2:0] qw_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic        [RAD_W-1:0]      rad_t;
  typedef logic        [ROOT_W-1:0]     root_t;
  typedef logic        [MAG_W-1:0]      mag_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rmq_in_if.sv =====
// Matrix channel: valid/ready handshake carrying the nine rotation entries.
// Depends on rmq_pkg.
`default_nettype none

interface rmq_in_if;
  import rmq_pkg::*;

  logic  valid;
  logic  ready;
  data_t r00;
  data_t r11;
  data_t r22;
  data_t r21;
  data_t r12;
  data_t r02;
  data_t r20;
  data_t r10;
  data_t r01;

  modport source (output valid, r00, r11, r22, r21, r12, r02, r20, r10, r01, input ready);
  modport sink   (input valid, r00, r11, r22, r21, r12, r02, r20, r10, r01, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rmq_out_if.sv =====
// Quaternion channel: valid/ready handshake carrying qw, qx, qy and qz.
// Depends on rmq_pkg.
`default_nettype none

interface rmq_out_if;
  import rmq_pkg::*;

  logic  valid;
  logic  ready;
  qw_t   qw;
  data_t qx;
  data_t qy;
  data_t qz;

  modport source (output valid, qw, qx, qy, qz, input ready);
  modport sink   (input valid, qw, qx, qy, qz, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion, signed Q2.14 in; qx, qy, qz signed Q2.14 and qw unsigned Q1.14 out.
//
// Channels: mat (sink) takes one word of nine rotation entries; quat (source)
// gives one word of qw, qx, qy, qz per matrix, in order. A word moves at a
// rising clock edge where valid and ready are both high.
//
// Pipeline: one sum stage, one stage per root bit in each of the four square root
// lanes, and one merge stage; quat.valid is the valid bit of the merge stage.
// Throughput: one matrix per cycle while mat.ready is high; the lanes are fully pipelined.
//
// Stall: each stage holds its word while the stage after it is full and
// stalled; empty stages keep filling, so mat.ready drops only when all
// stages hold words and quat.ready is low.
//
// Reset: rst clears all stage valid bits; no words are in flight afterward.
// Depends on rmq_pkg, rmq_in_if, rmq_out_if, rmq_front, rmq_sqrt_lane, rmq_merge.
`default_nettype none

module rotation_matrix_to_quaternion (
  input wire        clk,
  input wire        rst,
  rmq_in_if.sink    mat,
  rmq_out_if.source quat
);
  import rmq_pkg::*;

  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES:0]   rdy;
  logic [PIPE_STAGES-1:0] en;

  rad_t  [LANES-1:0] rad;
  root_t [LANES-1:0] root;
  logic  [LANES-2:0] neg;
  logic  [LANES-2:0] neg_pipe [ROOT_W];

  always_comb begin
    rdy[PIPE_STAGES] = quat.ready;
    for (int i = PIPE_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign en         = rdy[PIPE_STAGES-1:0];
  assign mat.ready  = rdy[0];
  assign quat.valid = vld[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= mat.valid;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      neg_pipe[0] <= neg;
    end
    for (int k = 1; k < ROOT_W; k++) begin
      if (en[k+1]) begin
        neg_pipe[k] <= neg_pipe[k-1];
      end
    end
  end

  rmq_front u_front (
    .clk (clk),
    .en  (en[0]),
    .r00 (mat.r00),
    .r11 (mat.r11),
    .r22 (mat.r22),
    .r21 (mat.r21),
    .r12 (mat.r12),
    .r02 (mat.r02),
    .r20 (mat.r20),
    .r10 (mat.r10),
    .r01 (mat.r01),
    .rad (rad),
    .neg (neg)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    rmq_sqrt_lane u_lane (
      .clk  (clk),
      .en   (en[ROOT_W:1]),
      .rad  (rad[l]),
      .root (root[l])
    );
  end

  rmq_merge u_merge (
    .clk  (clk),
    .en   (en[PIPE_STAGES-1]),
    .root (root),
    .neg  (neg_pipe[ROOT_W-1]),
    .qw   (quat.qw),
    .qx   (quat.qx),
    .qy   (quat.qy),
    .qz   (quat.qz)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/rmq_front.sv =====
// Front stage: diagonal sums, clamp at zero, radicand alignment and sign flags.
// Depends on rmq_pkg.
`default_nettype none

module rmq_front (
  input  wire                                 clk,
  input  wire                                 en,
  input  rmq_pkg::data_t                      r00,
  input  rmq_pkg::data_t                      r11,
  input  rmq_pkg::data_t                      r22,
  input  rmq_pkg::data_t                      r21,
  input  rmq_pkg::data_t                      r12,
  input  rmq_pkg::data_t                      r02,
  input  rmq_pkg::data_t                      r20,
  input  rmq_pkg::data_t                      r10,
  input  rmq_pkg::data_t                      r01,
  output rmq_pkg::rad_t [rmq_pkg::LANES-1:0]  rad,
  output logic [rmq_pkg::LANES-2:0]           neg
);
  import rmq_pkg::*;

  localparam sum_t ONE_SUM = sum_t'(ONE);

  function automatic sum_t ext(input data_t v);
    ext = {{(SUM_W - DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
  endfunction

  function automatic rad_t align(input sum_t s);
    logic [SUM_W-2:0] pos;
    pos = s[SUM_W-1] ? '0 : s[SUM_W-2:0];
    align = {{(RAD_W - SUM_W + 1){1'b0}}, pos} << (FRAC_BITS - 2);
  endfunction

  sum_t a, b, c;
  sum_t sum [LANES];

  assign a = ext(r00);
  assign b = ext(r11);
  assign c = ext(r22);

  assign sum[LANE_W] = ONE_SUM + a + b + c;
  assign sum[LANE_X] = ONE_SUM + a - b - c;
  assign sum[LANE_Y] = ONE_SUM - a + b - c;
  assign sum[LANE_Z] = ONE_SUM - a - b + c;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        rad[l] <= align(sum[l]);
      end
      neg[LANE_X-1] <= r21 < r12;
      neg[LANE_Y-1] <= r02 < r20;
      neg[LANE_Z-1] <= r10 < r01;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rmq_sqrt_lane.sv =====
// Square root lane: pipelined restoring square root, one result bit per stage.
// Depends on rmq_pkg.
`default_nettype none

module rmq_sqrt_lane (
  input  wire                          clk,
  input  wire [rmq_pkg::ROOT_W-1:0]    en,
  input  rmq_pkg::rad_t                rad,
  output rmq_pkg::root_t               root
);
  import rmq_pkg::*;

  root_t            root_q [ROOT_W];
  logic [REM_W-1:0] rem_q  [ROOT_W-1];
  rad_t             rad_q  [ROOT_W-1];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    logic [REM_W-1:0] rem_prev;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    root_t            root_prev;
    rad_t             rad_prev;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign rad_prev  = rad;
    end else begin : g_rest
      assign rem_prev  = rem_q[j-1];
      assign root_prev = root_q[j-1];
      assign rad_prev  = rad_q[j-1];
    end

    assign rem_sh  = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
    assign trial   = {1'b0, root_prev, 2'b01};
    assign ge      = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en[j]) begin
        root_q[j] <= {root_prev[ROOT_W-2:0], ge};
      end
    end

    if (j < ROOT_W - 1) begin : g_carry
      logic [REM_W-1:0] rem_new;

      assign rem_new = ge ? rem_sh - trial : rem_sh;

      always_ff @(posedge clk) begin
        if (en[j]) begin
          rem_q[j] <= rem_new;
          rad_q[j] <= {rad_prev[RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/rmq_merge.sv =====
// Merge stage: saturate each lane root at one, apply signs, register the word.
// Depends on rmq_pkg.
`default_nettype none

module rmq_merge (
  input  wire                                  clk,
  input  wire                                  en,
  input  rmq_pkg::root_t [rmq_pkg::LANES-1:0]  root,
  input  wire [rmq_pkg::LANES-2:0]             neg,
  output rmq_pkg::qw_t                         qw,
  output rmq_pkg::data_t                       qx,
  output rmq_pkg::data_t                       qy,
  output rmq_pkg::data_t                       qz
);
  import rmq_pkg::*;

  localparam root_t ONE_ROOT = root_t'(ONE);
  localparam mag_t  ONE_MAG  = mag_t'(ONE);

  function automatic mag_t sat(input root_t r);
    sat = (r > ONE_ROOT) ? ONE_MAG : r[MAG_W-1:0];
  endfunction

  function automatic data_t apply_sign(input mag_t m, input logic n);
    data_t v;
    v = {{(DATA_WIDTH - MAG_W){1'b0}}, m};
    apply_sign = n ? -v : v;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      qw <= (DATA_WIDTH-1)'(sat(root[LANE_W]));
      qx <= apply_sign(sat(root[LANE_X]), neg[LANE_X-1]);
      qy <= apply_sign(sat(root[LANE_Y]), neg[LANE_Y-1]);
      qz <= apply_sign(sat(root[LANE_Z]), neg[LANE_Z-1]);
    end
  end

endmodule

`default_nettype wire
